// ----- design/prft_pkg.sv -----
package prft_pkg;

  // Fixed field widths and formats of the ports.
  localparam int CoordW      = 32;
  localparam int HeadingW    = 26;
  localparam int InFrac      = 16;
  localparam int CfgIdxW     = 2;
  localparam int HalfTurnDeg = 180;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegOriginX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeading = 2'd2;

  // Scale of the decimal constant tables below.
  localparam longint unsigned DecOne = 64'd1000000000000;

  // One point travelling down the pipeline.
  typedef struct packed {
    logic                     opcode;
    logic                     neg;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } prft_item_t;

  // Decimal scaled constant to fixed point with frac fraction bits, rounded to nearest.
  function automatic longint unsigned dec_to_fix(longint unsigned v, int frac);
    longint unsigned q;
    longint unsigned r;
    q = v / DecOne;
    r = v % DecOne;
    return (q << frac) + ((r << frac) + DecOne / 64'd2) / DecOne;
  endfunction

  // Arctangent of 2^-i in degrees at frac fraction bits.
  function automatic longint unsigned atan_fix(int i, int frac);
    longint unsigned e;
    unique case (i)
      0:  e = 64'd45000000000000;
      1:  e = 64'd26565051177078;
      2:  e = 64'd14036243467926;
      3:  e = 64'd7125016348902;
      4:  e = 64'd3576334374997;
      5:  e = 64'd1789910608246;
      6:  e = 64'd895173710211;
      7:  e = 64'd447614170861;
      8:  e = 64'd223810500369;
      9:  e = 64'd111905677066;
      10: e = 64'd55952891894;
      11: e = 64'd27976452617;
      12: e = 64'd13988227142;
      13: e = 64'd6994113675;
      14: e = 64'd3497056851;
      15: e = 64'd1748528427;
      16: e = 64'd874264214;
      // Small angles: the arctangent equals its argument at this precision.
      default: e = (64'd57295779513082 + (64'd1 << (i - 1))) >> i;
    endcase
    return dec_to_fix(e, frac);
  endfunction

  // Reciprocal of the CORDIC gain after n stages at frac fraction bits.
  function automatic longint unsigned gain_fix(int n, int frac);
    longint unsigned e;
    priority if (n <= 8) begin
      e = 64'd607259112299;
    end else if (n > 16) begin
      e = 64'd607252935009;
    end else begin
      unique case (n)
        9:       e = 64'd607254479333;
        10:      e = 64'd607253321090;
        11:      e = 64'd607253031529;
        12:      e = 64'd607252959139;
        13:      e = 64'd607252941041;
        14:      e = 64'd607252936517;
        15:      e = 64'd607252935386;
        default: e = 64'd607252935103;
      endcase
    end
    return dec_to_fix(e, frac);
  endfunction

endpackage

// ----- design/prft_cell.sv -----
module prft_cell import prft_pkg::*; #(
  parameter int Stage = 0,
  parameter int Frac  = 16,
  parameter int XW    = 18,
  parameter int ZW    = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  prft_item_t           item_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output prft_item_t           item_o
);

  localparam logic signed [ZW-1:0] Atan = ZW'(atan_fix(Stage, Frac));

  logic signed [XW-1:0] xs, ys;
  logic signed [XW-1:0] x_d, y_d;
  logic signed [ZW-1:0] z_d;
  logic                 valid_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  prft_item_t           item_q;

  // One micro-rotation: the sign of the residual angle picks the direction.
  always_comb begin
    xs = x_i >>> Stage;
    ys = y_i >>> Stage;
    if (!z_i[ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    item_q <= item_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign item_o  = item_q;

endmodule

// ----- design/prft_rotate.sv -----
module prft_rotate import prft_pkg::*; #(
  parameter int XW   = 18,
  parameter int Frac = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [XW-1:0]     c_i,
  input  logic signed [XW-1:0]     s_i,
  input  prft_item_t               item_i,
  input  logic signed [CoordW-1:0] origin_x_i,
  input  logic signed [CoordW-1:0] origin_y_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic                     saturated_o
);

  localparam int AW = CoordW + 1;
  localparam int PW = XW + AW;
  localparam int SW = PW + 1;
  localparam int RW = SW - Frac;
  localparam int OW = RW + 1;
  localparam logic signed [SW-1:0] RoundHalf = SW'(1) <<< (Frac - 1);

  // Stage 1: fold the sign into sine and cosine, form the operand vector.
  logic                 v1_q, op1_q;
  logic signed [XW-1:0] c1_q, s1_q;
  logic signed [AW-1:0] a1_q, b1_q;
  logic signed [XW-1:0] c1_d, s1_d;
  logic signed [AW-1:0] a1_d, b1_d;

  always_comb begin
    c1_d = item_i.neg ? -c_i : c_i;
    s1_d = item_i.neg ? -s_i : s_i;
    if (item_i.opcode) begin
      a1_d = AW'(item_i.px);
      b1_d = AW'(item_i.py);
    end else begin
      a1_d = AW'(item_i.px) - AW'(origin_x_i);
      b1_d = AW'(item_i.py) - AW'(origin_y_i);
    end
  end

  // Stage 2: the four products.
  logic                 v2_q, op2_q;
  logic signed [PW-1:0] pca_q, psb_q, psa_q, pcb_q;
  logic signed [PW-1:0] pca_d, psb_d, psa_d, pcb_d;

  assign pca_d = c1_q * a1_q;
  assign psb_d = s1_q * b1_q;
  assign psa_d = s1_q * a1_q;
  assign pcb_d = c1_q * b1_q;

  // Stage 3: sum the products and round off the fraction bits.
  logic                 v3_q, op3_q;
  logic signed [RW-1:0] rx3_q, ry3_q;
  logic signed [SW-1:0] sx, sy, sx_r, sy_r;
  logic signed [RW-1:0] rx3_d, ry3_d;

  always_comb begin
    if (op2_q) begin
      sx = SW'(pca_q) + SW'(psb_q);
      sy = SW'(pcb_q) - SW'(psa_q);
    end else begin
      sx = SW'(pca_q) - SW'(psb_q);
      sy = SW'(psa_q) + SW'(pcb_q);
    end
    sx_r  = (sx + RoundHalf) >>> Frac;
    sy_r  = (sy + RoundHalf) >>> Frac;
    rx3_d = sx_r[RW-1:0];
    ry3_d = sy_r[RW-1:0];
  end

  // Output stage: add the origin for robot to world, then clamp.
  logic signed [OW-1:0]     fx, fy;
  logic                     ovx, ovy;
  logic signed [CoordW-1:0] ox_d, oy_d;
  logic                     done_q, sat_q;
  logic signed [CoordW-1:0] ox_q, oy_q;

  always_comb begin
    fx = OW'(rx3_q);
    fy = OW'(ry3_q);
    if (op3_q) begin
      fx = fx + OW'(origin_x_i);
      fy = fy + OW'(origin_y_i);
    end
    ovx = (fx[OW-1:CoordW-1] != {(OW-CoordW+1){1'b0}}) &&
          (fx[OW-1:CoordW-1] != {(OW-CoordW+1){1'b1}});
    ovy = (fy[OW-1:CoordW-1] != {(OW-CoordW+1){1'b0}}) &&
          (fy[OW-1:CoordW-1] != {(OW-CoordW+1){1'b1}});
    if (!ovx) begin
      ox_d = fx[CoordW-1:0];
    end else begin
      ox_d = fx[OW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
    if (!ovy) begin
      oy_d = fy[CoordW-1:0];
    end else begin
      oy_d = fy[OW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  // Data of the stages.
  always_ff @(posedge clk_i) begin
    op1_q <= item_i.opcode;
    c1_q  <= c1_d;
    s1_q  <= s1_d;
    a1_q  <= a1_d;
    b1_q  <= b1_d;
    op2_q <= op1_q;
    pca_q <= pca_d;
    psb_q <= psb_d;
    psa_q <= psa_d;
    pcb_q <= pcb_d;
    op3_q <= op2_q;
    rx3_q <= rx3_d;
    ry3_q <= ry3_d;
    ox_q  <= ox_d;
    oy_q  <= oy_d;
    sat_q <= ovx | ovy;
  end

  assign done_o      = done_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign saturated_o = sat_q;

endmodule

// ----- design/planar_rigid_frame_transform_top.sv -----
// A result strobes on done_o once it has passed the entry register, the CORDIC_STAGES cells and the rotate stages.
// Throughput: one word per cycle; busy stays low, since every stage passes on each cycle.
// The rate is set by the chain of CORDIC_STAGES rotation cells followed by a
// four stage multiply, round and clamp pipeline, each stage holding one word.
// Reset clears the configuration to zero and empties the pipeline.
// Results cannot be held off: each is shown for exactly one cycle.
module planar_rigid_frame_transform_top import prft_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode_i,
  input  logic signed [CoordW-1:0]   in_x_i,
  input  logic signed [CoordW-1:0]   in_y_i,
  output logic                       done_o,
  output logic signed [CoordW-1:0]   out_x_o,
  output logic signed [CoordW-1:0]   out_y_o,
  output logic                       saturated_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CoordW-1:0]          cfg_data_i
);

  localparam int XW = FRAC_BITS + 2;
  localparam int ZW = FRAC_BITS + 9;
  localparam int HW = HeadingW + 1;
  localparam logic signed [HW-1:0] HalfQ    = HW'(HalfTurnDeg << InFrac);
  localparam logic signed [HW-1:0] FullQ    = HW'((2 * HalfTurnDeg) << InFrac);
  localparam logic signed [HW-1:0] QuarterQ = HW'((HalfTurnDeg / 2) << InFrac);
  localparam logic signed [XW-1:0] GainFix  = XW'(gain_fix(CORDIC_STAGES, FRAC_BITS));

  // Configuration registers; the port never stalls.
  logic signed [CoordW-1:0]   origin_x_q, origin_y_q;
  logic signed [HeadingW-1:0] heading_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      heading_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegOriginX: origin_x_q <= cfg_data_i;
        RegOriginY: origin_y_q <= cfg_data_i;
        RegHeading: heading_q  <= cfg_data_i[HeadingW-1:0];
        default: ;
      endcase
    end
  end

  // Reduce the heading into (-180, 180], then fold it into [-90, 90].
  logic signed [HW-1:0] h_ext, h_red, h_fold;
  logic                 fold_neg;
  logic signed [ZW-1:0] z_start;

  always_comb begin
    h_ext = HW'(heading_q);
    priority if (h_ext > HalfQ) begin
      h_red = h_ext - FullQ;
    end else if (h_ext <= -HalfQ) begin
      h_red = h_ext + FullQ;
    end else begin
      h_red = h_ext;
    end
    fold_neg = 1'b1;
    priority if (h_red > QuarterQ) begin
      h_fold = h_red - HalfQ;
    end else if (h_red < -QuarterQ) begin
      h_fold = h_red + HalfQ;
    end else begin
      h_fold   = h_red;
      fold_neg = 1'b0;
    end
  end

  // Move the angle to the internal fraction width.
  if (FRAC_BITS >= InFrac) begin : g_z_widen
    assign z_start = ZW'(h_fold) <<< (FRAC_BITS - InFrac);
  end else begin : g_z_round
    logic signed [HW-1:0] h_rnd;
    assign h_rnd   = (h_fold + (HW'(1) <<< (InFrac - FRAC_BITS - 1))) >>> (InFrac - FRAC_BITS);
    assign z_start = ZW'(h_rnd);
  end

  // Entry register.
  logic       v0_q;
  logic signed [ZW-1:0] z0_q;
  prft_item_t item0_d, item0_q;

  always_comb begin
    item0_d.opcode = opcode_i;
    item0_d.neg    = fold_neg;
    item0_d.px     = in_x_i;
    item0_d.py     = in_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    z0_q    <= z_start;
    item0_q <= item0_d;
  end

  // Chain of rotation cells, one stage each.
  logic                 cv    [CORDIC_STAGES+1];
  logic signed [XW-1:0] cx    [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy    [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz    [CORDIC_STAGES+1];
  prft_item_t           citem [CORDIC_STAGES+1];

  assign cv[0]    = v0_q;
  assign cx[0]    = GainFix;
  assign cy[0]    = '0;
  assign cz[0]    = z0_q;
  assign citem[0] = item0_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    prft_cell #(
      .Stage (i),
      .Frac  (FRAC_BITS),
      .XW    (XW),
      .ZW    (ZW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .item_i  (citem[i]),
      .valid_o (cv[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1]),
      .item_o  (citem[i+1])
    );
  end

  // Rotation by the heading matrix, rounding and clamping.
  prft_rotate #(
    .XW   (XW),
    .Frac (FRAC_BITS)
  ) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cv[CORDIC_STAGES]),
    .c_i         (cx[CORDIC_STAGES]),
    .s_i         (cy[CORDIC_STAGES]),
    .item_i      (citem[CORDIC_STAGES]),
    .origin_x_i  (origin_x_q),
    .origin_y_i  (origin_y_q),
    .done_o      (done_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .saturated_o (saturated_o)
  );

endmodule
